// ===== hw/rtl/potential_field_repulsion_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the potential field repulsion block
// Implication checks sampled on the rising clock edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef POTENTIAL_FIELD_REPULSION_DEFINES_SVH
`define POTENTIAL_FIELD_REPULSION_DEFINES_SVH

// same-cycle implication
`define PFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared widths, register codes and per-beat flags of the repulsion pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = 33;
  localparam int ABS_W      = 32;
  localparam int MAG_W      = 31;
  localparam int GAIN_W     = 32;
  localparam int THR_W      = 31;
  localparam int D2_W       = 62;
  localparam int ROOT_W     = 31;
  localparam int SQ_W       = 124;
  localparam int GT_W       = 63;
  localparam int PP_W       = 63;
  localparam int PROD_W     = 94;
  localparam int DEN_W      = 155;
  localparam int Q_W        = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int GEOM_PRE   = 4;
  localparam int SQRT_STEPS = 31;

  localparam logic [GAIN_W-1:0] GAIN_RST = 32'd65536;
  localparam logic [THR_W-1:0]  THR_RST  = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN = 1'b0,
    REG_THR  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic far;
    logic zero;
  } item_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfr_geom.sv =====
// ----------------------------------------------------------------------------
// pfr_geom
// Difference, magnitudes, squared distance, range test and pipelined isqrt.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfr_geom (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 in_valid_i,
  input  logic signed [pfr_pkg::COORD_W-1:0]   robot_x_i,
  input  logic signed [pfr_pkg::COORD_W-1:0]   robot_y_i,
  input  logic signed [pfr_pkg::COORD_W-1:0]   point_x_i,
  input  logic signed [pfr_pkg::COORD_W-1:0]   point_y_i,
  input  logic        [pfr_pkg::THR_W-1:0]     thr_i,
  input  logic        [pfr_pkg::D2_W-1:0]      thr_sq_i,
  output logic                                 out_valid_o,
  output pfr_pkg::item_flags_t                 flags_o,
  output logic        [pfr_pkg::MAG_W-1:0]     ax_o,
  output logic        [pfr_pkg::MAG_W-1:0]     ay_o,
  output logic        [pfr_pkg::D2_W-1:0]      d2_o,
  output logic        [pfr_pkg::ROOT_W-1:0]    root_o
);

  localparam int NS = pfr_pkg::GEOM_PRE + pfr_pkg::SQRT_STEPS + 1;
  localparam int NR = pfr_pkg::SQRT_STEPS + 1;

  logic [NS-1:0] v_q;

  logic [pfr_pkg::DIFF_W-1:0] dx_q, dy_q;
  logic [pfr_pkg::DIFF_W-1:0] ndx, ndy;
  logic [pfr_pkg::ABS_W-1:0]  abs_x, abs_y;

  logic [pfr_pkg::MAG_W-1:0]  ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q;
  pfr_pkg::item_flags_t       flg1_q, flg2_q, flg3_q;
  logic [pfr_pkg::D2_W-1:0]   sqx_q, sqy_q;
  logic [pfr_pkg::D2_W:0]     d2s_q;

  logic [pfr_pkg::D2_W-1:0]   rem_q  [NR];
  logic [pfr_pkg::ROOT_W-1:0] root_q [NR];
  logic [pfr_pkg::D2_W-1:0]   d2c_q  [NR];
  logic [pfr_pkg::MAG_W-1:0]  axc_q  [NR];
  logic [pfr_pkg::MAG_W-1:0]  ayc_q  [NR];
  pfr_pkg::item_flags_t       flgc_q [NR];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  assign ndx   = -dx_q;
  assign ndy   = -dy_q;
  assign abs_x = dx_q[pfr_pkg::DIFF_W-1] ? ndx[pfr_pkg::ABS_W-1:0] : dx_q[pfr_pkg::ABS_W-1:0];
  assign abs_y = dy_q[pfr_pkg::DIFF_W-1] ? ndy[pfr_pkg::ABS_W-1:0] : dy_q[pfr_pkg::ABS_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= {robot_x_i[pfr_pkg::COORD_W-1], robot_x_i}
            - {point_x_i[pfr_pkg::COORD_W-1], point_x_i};
      dy_q <= {robot_y_i[pfr_pkg::COORD_W-1], robot_y_i}
            - {point_y_i[pfr_pkg::COORD_W-1], point_y_i};

      ax1_q        <= abs_x[pfr_pkg::MAG_W-1:0];
      ay1_q        <= abs_y[pfr_pkg::MAG_W-1:0];
      flg1_q.neg_x <= dx_q[pfr_pkg::DIFF_W-1];
      flg1_q.neg_y <= dy_q[pfr_pkg::DIFF_W-1];
      flg1_q.far   <= (abs_x >= {1'b0, thr_i}) || (abs_y >= {1'b0, thr_i});
      flg1_q.zero  <= 1'b0;

      sqx_q  <= ax1_q * ax1_q;
      sqy_q  <= ay1_q * ay1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      flg2_q <= flg1_q;

      d2s_q  <= {1'b0, sqx_q} + {1'b0, sqy_q};
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      flg3_q <= flg2_q;

      rem_q[0]       <= d2s_q[pfr_pkg::D2_W-1:0];
      root_q[0]      <= '0;
      d2c_q[0]       <= d2s_q[pfr_pkg::D2_W-1:0];
      axc_q[0]       <= ax3_q;
      ayc_q[0]       <= ay3_q;
      flgc_q[0].neg_x <= flg3_q.neg_x;
      flgc_q[0].neg_y <= flg3_q.neg_y;
      flgc_q[0].far   <= flg3_q.far || (d2s_q >= {1'b0, thr_sq_i});
      flgc_q[0].zero  <= (d2s_q == '0);
    end
  end

  // one root bit per stage, remainder form
  for (genvar j = 1; j < NR; j++) begin : g_sqrt
    localparam int BI = pfr_pkg::SQRT_STEPS - j;
    logic [pfr_pkg::D2_W+1:0] trial;
    logic                     take;

    assign trial = ({{(pfr_pkg::D2_W+2-pfr_pkg::ROOT_W){1'b0}}, root_q[j-1]} << (BI + 1))
                 + ({{(pfr_pkg::D2_W+1){1'b0}}, 1'b1} << (2 * BI));
    assign take  = {2'b00, rem_q[j-1]} >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? rem_q[j-1] - trial[pfr_pkg::D2_W-1:0] : rem_q[j-1];
        root_q[j] <= take ? (root_q[j-1] | ({{(pfr_pkg::ROOT_W-1){1'b0}}, 1'b1} << BI))
                          : root_q[j-1];
        d2c_q[j]  <= d2c_q[j-1];
        axc_q[j]  <= axc_q[j-1];
        ayc_q[j]  <= ayc_q[j-1];
        flgc_q[j] <= flgc_q[j-1];
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign flags_o     = flgc_q[NR-1];
  assign ax_o        = axc_q[NR-1];
  assign ay_o        = ayc_q[NR-1];
  assign d2_o        = d2c_q[NR-1];
  assign root_o      = root_q[NR-1];

endmodule

`default_nettype wire

// ===== hw/rtl/pfr_prod.sv =====
// ----------------------------------------------------------------------------
// pfr_prod
// Numerators G*(T-d)*|dx|, |dy| and denominator T*D2^2 from 32-bit partials.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfr_prod (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  pfr_pkg::item_flags_t              flags_i,
  input  logic [pfr_pkg::MAG_W-1:0]         ax_i,
  input  logic [pfr_pkg::MAG_W-1:0]         ay_i,
  input  logic [pfr_pkg::D2_W-1:0]          d2_i,
  input  logic [pfr_pkg::ROOT_W-1:0]        root_i,
  input  logic [pfr_pkg::GAIN_W-1:0]        gain_i,
  input  logic [pfr_pkg::THR_W-1:0]         thr_i,
  output logic                              out_valid_o,
  output pfr_pkg::item_flags_t              flags_o,
  output logic [pfr_pkg::DEN_W-1:0]         den_o,
  output logic [pfr_pkg::PROD_W-1:0]        numx_o,
  output logic [pfr_pkg::PROD_W-1:0]        numy_o
);

  localparam int NS = 4;

  logic [NS-1:0] v_q;

  pfr_pkg::item_flags_t             flg1_q, flg2_q, flg3_q, flg4_q;
  logic [pfr_pkg::MAG_W-1:0]        ax1_q, ay1_q, ax2_q, ay2_q;
  logic [pfr_pkg::THR_W-1:0]        tmd_q;
  logic [59:0]                      hh_q;
  logic [61:0]                      hl_q;
  logic [63:0]                      ll_q;
  logic [pfr_pkg::SQ_W-1:0]         sq_q;
  logic [pfr_pkg::GT_W-1:0]         gt_q;
  logic [pfr_pkg::PP_W-1:0]         pd0_q, pd1_q, pd2_q, pd3_q;
  logic [pfr_pkg::PP_W-1:0]         px0_q, px1_q, py0_q, py1_q;
  logic [pfr_pkg::DEN_W-1:0]        den_q;
  logic [pfr_pkg::PROD_W-1:0]       numx_q, numy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tmd_q  <= thr_i - root_i;
      hh_q   <= d2_i[61:32] * d2_i[61:32];
      hl_q   <= d2_i[61:32] * d2_i[31:0];
      ll_q   <= d2_i[31:0] * d2_i[31:0];
      ax1_q  <= ax_i;
      ay1_q  <= ay_i;
      flg1_q <= flags_i;

      sq_q   <= ({{(pfr_pkg::SQ_W-60){1'b0}}, hh_q} << 64)
              + ({{(pfr_pkg::SQ_W-62){1'b0}}, hl_q} << 33)
              + {{(pfr_pkg::SQ_W-64){1'b0}}, ll_q};
      gt_q   <= gain_i * tmd_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      flg2_q <= flg1_q;

      pd0_q  <= sq_q[31:0] * thr_i;
      pd1_q  <= sq_q[63:32] * thr_i;
      pd2_q  <= sq_q[95:64] * thr_i;
      pd3_q  <= sq_q[123:96] * thr_i;
      px0_q  <= gt_q[31:0] * ax2_q;
      px1_q  <= gt_q[62:32] * ax2_q;
      py0_q  <= gt_q[31:0] * ay2_q;
      py1_q  <= gt_q[62:32] * ay2_q;
      flg3_q <= flg2_q;

      den_q  <= {{(pfr_pkg::DEN_W-pfr_pkg::PP_W){1'b0}}, pd0_q}
              + ({{(pfr_pkg::DEN_W-pfr_pkg::PP_W){1'b0}}, pd1_q} << 32)
              + ({{(pfr_pkg::DEN_W-pfr_pkg::PP_W){1'b0}}, pd2_q} << 64)
              + ({{(pfr_pkg::DEN_W-pfr_pkg::PP_W){1'b0}}, pd3_q} << 96);
      numx_q <= {{(pfr_pkg::PROD_W-pfr_pkg::PP_W){1'b0}}, px0_q}
              + ({{(pfr_pkg::PROD_W-pfr_pkg::PP_W){1'b0}}, px1_q} << 32);
      numy_q <= {{(pfr_pkg::PROD_W-pfr_pkg::PP_W){1'b0}}, py0_q}
              + ({{(pfr_pkg::PROD_W-pfr_pkg::PP_W){1'b0}}, py1_q} << 32);
      flg4_q <= flg3_q;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign flags_o     = flg4_q;
  assign den_o       = den_q;
  assign numx_o      = numx_q;
  assign numy_o      = numy_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pfr_div.sv =====
// ----------------------------------------------------------------------------
// pfr_div
// Pipelined restoring divide for both components, saturation, output skid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfr_div #(
  parameter int FRAC_BITS = pfr_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  pfr_pkg::item_flags_t               flags_i,
  input  logic [pfr_pkg::DEN_W-1:0]          den_i,
  input  logic [pfr_pkg::PROD_W-1:0]         numx_i,
  input  logic [pfr_pkg::PROD_W-1:0]         numy_i,
  input  logic                               out_stall_i,
  output logic                               en_o,
  output logic                               out_valid_o,
  output logic signed [pfr_pkg::Q_W-1:0]     force_x_o,
  output logic signed [pfr_pkg::Q_W-1:0]     force_y_o,
  output logic                               within_range_o,
  output logic                               saturated_o
);

  localparam int QW   = pfr_pkg::Q_W;
  localparam int NUMW = pfr_pkg::PROD_W + 3 * FRAC_BITS;
  localparam int CMPW = ((NUMW > pfr_pkg::DEN_W) ? NUMW : pfr_pkg::DEN_W) + QW + 1;
  localparam int NS   = QW + 1;

  typedef struct packed {
    logic [QW-1:0] f;
    logic          s;
  } comp_t;

  typedef struct packed {
    logic [QW-1:0] fx;
    logic [QW-1:0] fy;
    logic          in_range;
    logic          sat;
  } result_t;

  function automatic comp_t fmt(input logic neg, input logic ov, input logic [QW-1:0] q);
    logic [QW:0] m;
    comp_t       r;
    m = ov ? {1'b1, {QW{1'b0}}} : {1'b0, q};
    if (!neg) begin
      r.s = m > {2'b00, {(QW-1){1'b1}}};
      r.f = r.s ? {1'b0, {(QW-1){1'b1}}} : m[QW-1:0];
    end else begin
      r.s = m > {2'b01, {(QW-1){1'b0}}};
      r.f = r.s ? {1'b1, {(QW-1){1'b0}}} : (~m[QW-1:0]) + 1'b1;
    end
    return r;
  endfunction

  logic [NS-1:0] v_q;

  logic [NUMW-1:0]            rx_q  [NS];
  logic [NUMW-1:0]            ry_q  [NS];
  logic [QW-1:0]              qx_q  [NS];
  logic [QW-1:0]              qy_q  [NS];
  logic [pfr_pkg::DEN_W-1:0]  den_q [NS];
  pfr_pkg::item_flags_t       flg_q [NS];
  logic                       ovx_q [NS];
  logic                       ovy_q [NS];

  logic [NUMW-1:0] nx0, ny0;
  logic [CMPW-1:0] lim0;

  comp_t   cx, cy;
  result_t res;
  result_t out_q, skid_q;
  logic    out_v_q, skid_v_q;
  logic    push, pop;

  assign en_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_o) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  assign nx0  = {{(NUMW-pfr_pkg::PROD_W){1'b0}}, numx_i} << (3 * FRAC_BITS);
  assign ny0  = {{(NUMW-pfr_pkg::PROD_W){1'b0}}, numy_i} << (3 * FRAC_BITS);
  assign lim0 = {{(CMPW-pfr_pkg::DEN_W){1'b0}}, den_i} << QW;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      rx_q[0]  <= nx0;
      ry_q[0]  <= ny0;
      qx_q[0]  <= '0;
      qy_q[0]  <= '0;
      den_q[0] <= den_i;
      flg_q[0] <= flags_i;
      ovx_q[0] <= {{(CMPW-NUMW){1'b0}}, nx0} >= lim0;
      ovy_q[0] <= {{(CMPW-NUMW){1'b0}}, ny0} >= lim0;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar j = 1; j < NS; j++) begin : g_div
    localparam int BB = QW - j;
    logic [CMPW-1:0] sh;
    logic            tx, ty;

    assign sh = {{(CMPW-pfr_pkg::DEN_W){1'b0}}, den_q[j-1]} << BB;
    assign tx = {{(CMPW-NUMW){1'b0}}, rx_q[j-1]} >= sh;
    assign ty = {{(CMPW-NUMW){1'b0}}, ry_q[j-1]} >= sh;

    always_ff @(posedge clk_i) begin
      if (en_o) begin
        rx_q[j]  <= tx ? rx_q[j-1] - sh[NUMW-1:0] : rx_q[j-1];
        ry_q[j]  <= ty ? ry_q[j-1] - sh[NUMW-1:0] : ry_q[j-1];
        qx_q[j]  <= tx ? (qx_q[j-1] | ({{(QW-1){1'b0}}, 1'b1} << BB)) : qx_q[j-1];
        qy_q[j]  <= ty ? (qy_q[j-1] | ({{(QW-1){1'b0}}, 1'b1} << BB)) : qy_q[j-1];
        den_q[j] <= den_q[j-1];
        flg_q[j] <= flg_q[j-1];
        ovx_q[j] <= ovx_q[j-1];
        ovy_q[j] <= ovy_q[j-1];
      end
    end
  end

  always_comb begin
    cx = fmt(flg_q[NS-1].neg_x, ovx_q[NS-1], qx_q[NS-1]);
    cy = fmt(flg_q[NS-1].neg_y, ovy_q[NS-1], qy_q[NS-1]);
    if (flg_q[NS-1].far) begin
      res = '0;
    end else if (flg_q[NS-1].zero) begin
      res          = '0;
      res.in_range = 1'b1;
      res.sat      = 1'b1;
    end else begin
      res.fx       = cx.f;
      res.fy       = cy.f;
      res.in_range = 1'b1;
      res.sat      = cx.s || cy.s;
    end
  end

  assign push = en_o && v_q[NS-1];
  assign pop  = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign force_x_o      = out_q.fx;
  assign force_y_o      = out_q.fy;
  assign within_range_o = out_q.in_range;
  assign saturated_o    = out_q.sat;

endmodule

`default_nettype wire

// ===== hw/rtl/potential_field_repulsion.sv =====
// ----------------------------------------------------------------------------
// potential_field_repulsion
// Repulsive force of one laser point on the robot, Q.FRAC_BITS fixed point.
//
//   channel  dir  handshake             beat
//   in       in   in_valid_i/in_stall_o  robot_x/y, point_x/y
//   out      out  out_valid_o/out_stall_i force_x/y, within_range, saturated
//   cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per cycle while in_stall_o is low; 36 geometry/isqrt stages, 4 product
// stages, 33 divide stages, output register.
// Reset clears valids and loads gain and threshold with 1.0.
// A stalled result sits in the output register; one more beat lands in the
// skid entry, after which the whole pipeline holds and in_stall_o rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "potential_field_repulsion_defines.svh"

module potential_field_repulsion #(
  parameter int FRAC_BITS = pfr_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pfr_pkg::COORD_W-1:0]   robot_x_i,
  input  logic signed [pfr_pkg::COORD_W-1:0]   robot_y_i,
  input  logic signed [pfr_pkg::COORD_W-1:0]   point_x_i,
  input  logic signed [pfr_pkg::COORD_W-1:0]   point_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pfr_pkg::Q_W-1:0]       force_x_o,
  output logic signed [pfr_pkg::Q_W-1:0]       force_y_o,
  output logic                                 within_range_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [pfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [pfr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [pfr_pkg::GAIN_W-1:0] gain_q;
  logic [pfr_pkg::THR_W-1:0]  thr_q;
  logic [pfr_pkg::D2_W-1:0]   thr_sq_q;

  logic en;

  logic                        g_valid;
  pfr_pkg::item_flags_t        g_flags;
  logic [pfr_pkg::MAG_W-1:0]   g_ax, g_ay;
  logic [pfr_pkg::D2_W-1:0]    g_d2;
  logic [pfr_pkg::ROOT_W-1:0]  g_root;

  logic                        p_valid;
  pfr_pkg::item_flags_t        p_flags;
  logic [pfr_pkg::DEN_W-1:0]   p_den;
  logic [pfr_pkg::PROD_W-1:0]  p_numx, p_numy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= pfr_pkg::GAIN_RST;
      thr_q  <= pfr_pkg::THR_RST;
    end else if (cfg_valid_i) begin
      unique case (pfr_pkg::cfg_reg_e'(cfg_index_i))
        pfr_pkg::REG_GAIN: gain_q <= cfg_data_i;
        pfr_pkg::REG_THR:  thr_q  <= cfg_data_i[pfr_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    thr_sq_q <= thr_q * thr_q;
  end

  assign in_stall_o = !en;

  pfr_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .robot_x_i   (robot_x_i),
    .robot_y_i   (robot_y_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .thr_i       (thr_q),
    .thr_sq_i    (thr_sq_q),
    .out_valid_o (g_valid),
    .flags_o     (g_flags),
    .ax_o        (g_ax),
    .ay_o        (g_ay),
    .d2_o        (g_d2),
    .root_o      (g_root)
  );

  pfr_prod u_prod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (g_valid),
    .flags_i     (g_flags),
    .ax_i        (g_ax),
    .ay_i        (g_ay),
    .d2_i        (g_d2),
    .root_i      (g_root),
    .gain_i      (gain_q),
    .thr_i       (thr_q),
    .out_valid_o (p_valid),
    .flags_o     (p_flags),
    .den_o       (p_den),
    .numx_o      (p_numx),
    .numy_o      (p_numy)
  );

  pfr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (p_valid),
    .flags_i        (p_flags),
    .den_i          (p_den),
    .numx_i         (p_numx),
    .numy_i         (p_numy),
    .out_stall_i    (out_stall_i),
    .en_o           (en),
    .out_valid_o    (out_valid_o),
    .force_x_o      (force_x_o),
    .force_y_o      (force_y_o),
    .within_range_o (within_range_o),
    .saturated_o    (saturated_o)
  );

  `PFR_ASSERT_IMP(a_far_zero, clk_i, rst_ni, out_valid_o && !within_range_o, (force_x_o == '0) && (force_y_o == '0) && !saturated_o, "out of range beat carries force or flag")
  `PFR_ASSERT_IMP(a_empty_accepts, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled with empty output")
  `PFR_ASSERT_NXT(a_skid_holds, clk_i, rst_ni, in_stall_o && out_stall_i, in_stall_o, "skid entry lost while output stalled")

endmodule

`default_nettype wire

// ===== verif/potential_field_repulsion_tb.sv =====
// ----------------------------------------------------------------------------
// potential_field_repulsion_tb
// Drives laser points through the repulsion pipeline and checks each force
// beat against a bit-exact fixed-point predictor. Configuration changes
// between phases, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module potential_field_repulsion_tb;

  localparam int FB   = pfr_pkg::FRAC_BITS_DEF;
  localparam int DRAIN = 80;

  typedef struct {
    logic [31:0] fx;
    logic [31:0] fy;
    logic        wr;
    logic        sat;
  } force_t;

  typedef struct {
    logic [31:0] rx, ry, px, py;
    bit          known;
    force_t      res;
  } point_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] robot_x_i = '0, robot_y_i = '0, point_x_i = '0, point_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] force_x_o, force_y_o;
  logic within_range_o, saturated_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index_i = pfr_pkg::REG_GAIN;
  logic [31:0] cfg_data_i = '0;

  potential_field_repulsion u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .robot_x_i, .robot_y_i, .point_x_i, .point_y_i,
    .out_valid_o, .out_stall_i, .force_x_o, .force_y_o,
    .within_range_o, .saturated_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  logic [31:0] gain_q = pfr_pkg::GAIN_RST;
  logic [30:0] thr_q  = pfr_pkg::THR_RST;
  force_t      force_q[$];
  force_t      typed_q[$];
  int          errors = 0;
  int          beats_in = 0;
  int          cfg_beats = 0;
  bit          quiet = 0;
  bit          hold_req = 0;

  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if ({32'd0, c} * {32'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] component(logic signed [33:0] dev, logic [31:0] tmd,
                                             logic [255:0] den, ref logic sat);
    logic [255:0] num, q;
    logic [32:0]  mag;
    mag = dev < 0 ? 33'(-dev) : 33'(dev);
    num = (256'(gain_q) * 256'(tmd) * 256'(mag)) << (3 * FB);
    q = num / den;
    if (q > 256'h1_0000_0000) q = 256'h1_0000_0000;
    if (dev >= 0) begin
      if (q > 256'h7FFF_FFFF) begin
        sat = 1'b1;
        q = 256'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 256'h8000_0000) begin
      sat = 1'b1;
      q = 256'h8000_0000;
    end
    return 32'd0 - q[31:0];
  endfunction

  function automatic force_t repulsion_force(logic [31:0] rx, ry, px, py);
    force_t r;
    logic signed [33:0] dx, dy;
    logic [33:0] ax, ay;
    logic [63:0] d2;
    logic [31:0] tmd;
    logic [255:0] den;
    logic sat;
    r = '{fx: '0, fy: '0, wr: 1'b0, sat: 1'b0};
    dx = $signed({{2{rx[31]}}, rx}) - $signed({{2{px[31]}}, px});
    dy = $signed({{2{ry[31]}}, ry}) - $signed({{2{py[31]}}, py});
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax >= 34'(thr_q) || ay >= 34'(thr_q)) return r;
    d2 = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
    if (d2 >= 64'(thr_q) * 64'(thr_q)) return r;
    r.wr = 1'b1;
    if (d2 == 0) begin
      r.sat = 1'b1;
      return r;
    end
    tmd = 32'(thr_q) - isqrt(d2);
    den = 256'(d2) * 256'(d2) * 256'(thr_q);
    sat = 1'b0;
    r.fx = component(dx, tmd, den, sat);
    r.fy = component(dy, tmd, den, sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // acceptance monitor: predicts on input beats, checks on output beats
  always @(posedge clk_i) begin
    force_t e;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == pfr_pkg::REG_GAIN) gain_q = cfg_data_i;
      else thr_q = cfg_data_i[30:0];
      cfg_beats++;
    end
    if (in_valid_i && !in_stall_o) begin
      e = repulsion_force(robot_x_i, robot_y_i, point_x_i, point_y_i);
      if (typed_q.size() > 0) e = typed_q.pop_front();
      force_q.push_back(e);
      beats_in++;
    end
    if (out_valid_o && !out_stall_i) begin
      if (force_q.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        e = force_q.pop_front();
        if (force_x_o !== e.fx) report_mismatch("force_x", force_x_o, e.fx);
        if (force_y_o !== e.fy) report_mismatch("force_y", force_y_o, e.fy);
        if (within_range_o !== e.wr) report_mismatch("within_range", within_range_o, e.wr);
        if (saturated_o !== e.sat) report_mismatch("saturated", saturated_o, e.sat);
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_req = 0;
        out_stall_i = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_point(logic [31:0] rx, ry, px, py);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    robot_x_i = rx;
    robot_y_i = ry;
    point_x_i = px;
    point_y_i = py;
    in_valid_i = 1'b1;
    n = beats_in;
    do @(negedge clk_i); while (beats_in == n);
  endtask

  task automatic write_reg(pfr_pkg::cfg_reg_e idx, logic [31:0] data);
    int n;
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    n = cfg_beats;
    do @(negedge clk_i); while (cfg_beats == n);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (force_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic random_points(int count);
    logic [31:0] rx, ry;
    longint lim, ddx, ddy;
    for (int i = 0; i < count; i++) begin
      rx = $urandom();
      ry = $urandom();
      case ($urandom_range(0, 7))
        0, 1: begin
          send_point(rx, ry, $urandom(), $urandom());
        end
        2: begin
          ddx = longint'($urandom_range(0, 6)) - 3;
          ddy = longint'($urandom_range(0, 6)) - 3;
          send_point(rx, ry, rx - 32'(ddx), ry - 32'(ddy));
        end
        default: begin
          lim = longint'(thr_q) + 2;
          if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
          ddx = longint'($urandom_range(0, 32'(2 * lim))) - lim;
          ddy = longint'($urandom_range(0, 32'(2 * lim))) - lim;
          if ($urandom_range(0, 1)) ddy = ddy / 4;
          send_point(rx, ry, rx - 32'(ddx), ry - 32'(ddy));
        end
      endcase
    end
  endtask

  point_row_t rows[] = '{
    '{32'd5, 32'd7, 32'd5, 32'd7, 1, '{32'd0, 32'd0, 1'b1, 1'b1}},
    '{32'd65536, 32'd0, 32'd0, 32'd0, 1, '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1,
      '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
      '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{32'd1, 32'd0, 32'd0, 32'd0, 1, '{32'h7FFF_FFFF, 32'd0, 1'b1, 1'b1}},
    '{32'd0, 32'd0, 32'd1, 32'd0, 1, '{32'h8000_0000, 32'd0, 1'b1, 1'b1}},
    '{32'd0, 32'd1, 32'd0, 32'd0, 1, '{32'd0, 32'h7FFF_FFFF, 1'b1, 1'b1}},
    '{32'd0, 32'd0, 32'd0, 32'd1, 1, '{32'd0, 32'h8000_0000, 1'b1, 1'b1}},
    '{32'd46341, 32'd46341, 32'd0, 32'd0, 1, '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{32'd32768, 32'd0, 32'd0, 32'd0, 0, '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{32'd40000, 32'd0, 32'd0, 32'd40000, 0, '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{32'd65535, 32'd0, 32'd0, 32'd0, 0, '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{32'd46340, 32'd46340, 32'd0, 32'd0, 0, '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FF9B, 32'h8000_0020, 0,
      '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{32'hFFFF_FF00, 32'h0000_0100, 32'hFFFF_F000, 32'h0000_0300, 0,
      '{32'd0, 32'd0, 1'b0, 1'b0}}
  };

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // directed beats at the reset configuration
    foreach (rows[i]) begin
      if (rows[i].known) typed_q.push_back(rows[i].res);
      else typed_q.push_back(repulsion_force(rows[i].rx, rows[i].ry, rows[i].px,
                                             rows[i].py));
      send_point(rows[i].rx, rows[i].ry, rows[i].px, rows[i].py);
    end
    drain();

    write_reg(pfr_pkg::REG_GAIN, 32'hFFFF_FFFF);
    write_reg(pfr_pkg::REG_THR, 32'h7FFF_FFFF);
    random_points(60);
    drain();

    write_reg(pfr_pkg::REG_GAIN, 32'd0);
    write_reg(pfr_pkg::REG_THR, 32'd262144);
    hold_req = 1;
    random_points(70);
    drain();

    write_reg(pfr_pkg::REG_GAIN, $urandom());
    write_reg(pfr_pkg::REG_THR, 32'd1);
    random_points(40);
    drain();

    write_reg(pfr_pkg::REG_GAIN, 32'd196608);
    write_reg(pfr_pkg::REG_THR, 32'd6553600);
    random_points(70);
    drain();

    write_reg(pfr_pkg::REG_THR, 32'd0);
    random_points(30);
    drain();

    write_reg(pfr_pkg::REG_GAIN, $urandom());
    write_reg(pfr_pkg::REG_THR, $urandom_range(32, 1 << 20));
    random_points(70);
    drain();

    quiet = 1;
    write_reg(pfr_pkg::REG_GAIN, 32'd65536);
    write_reg(pfr_pkg::REG_THR, 32'd65536);
    random_points(60);
    drain();

    if (errors == 0) begin
      $display("PASS potential_field_repulsion");
    end else begin
      $display("FAIL potential_field_repulsion");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL potential_field_repulsion");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_geom.sv
hw/rtl/pfr_prod.sv
hw/rtl/pfr_div.sv
hw/rtl/potential_field_repulsion.sv
verif/potential_field_repulsion_tb.sv
